// ===== rtl/core/rle_image_stream_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// RLE image stream decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ---------------------------------------------------------------------------
`ifndef RLE_IMAGE_STREAM_DECODER_DEFINES_SVH
`define RLE_IMAGE_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RLSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlsd assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RLSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlsd assertion failed");

`endif

// ===== rtl/core/rlsd_pkg.sv =====
// ---------------------------------------------------------------------------
// RLE image stream decoder package
// Result kinds, header layout, parse phases and the result record type.
// ---------------------------------------------------------------------------
package rlsd_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_RUN    = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Header magic and the accepted pixel depths.
   localparam logic [7:0] MAGIC_R   = 8'h52;
   localparam logic [7:0] MAGIC_L   = 8'h4C;
   localparam logic [7:0] MAGIC_E   = 8'h45;
   localparam logic [7:0] DEPTH_8   = 8'd8;
   localparam logic [7:0] DEPTH_16  = 8'd16;

   // Header byte positions.
   localparam logic [3:0] HDR_POS_R     = 4'd0;
   localparam logic [3:0] HDR_POS_L     = 4'd1;
   localparam logic [3:0] HDR_POS_E     = 4'd2;
   localparam logic [3:0] HDR_POS_DEPTH = 4'd3;
   localparam logic [3:0] HDR_POS_LEN0  = 4'd4;
   localparam logic [3:0] HDR_POS_LEN3  = 4'd7;
   localparam logic [3:0] HDR_POS_WID0  = 4'd8;
   localparam logic [3:0] HDR_POS_WID1  = 4'd9;
   localparam logic [3:0] HDR_POS_LAST  = 4'd11;

   // Configuration register indexes.
   localparam logic REG_TRANSPARENT_COLOR   = 1'b0;
   localparam logic REG_TRANSPARENCY_ENABLE = 1'b1;

   // Result queue depth.
   localparam int unsigned RESULT_DEPTH = 4;
   localparam int unsigned RESULT_PTR_W = $clog2(RESULT_DEPTH);
   localparam int unsigned RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

   // Parse phases, one-hot.
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_DATA   = 4'b0010,
      PH_LEN_HI = 4'b0100,
      PH_LEN_LO = 4'b1000
   } phase_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] start_index;
      logic [15:0] run_length;
      logic [7:0]  color;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        end_of_image;
   } result_type;

endpackage

// ===== rtl/core/rle_image_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// RLE image stream decoder
// Parses an RLE image header and decodes the 8-bit palette payload into runs.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Carries
//  req_     | in        | req_valid/req_stall  | one stream byte per transfer
//  rsp_     | out       | rsp_valid/rsp_stall  | one result per transfer
//  APB      | in/out    | psel/penable, pready | transparency registers
//
// Each accepted byte is decoded in the cycle it is accepted; its zero, one
// or two results enter a four-entry result queue and leave one per cycle unless stalled.
// A byte is accepted every cycle while the queue holds at most two results,
// so the sustained rate is one byte per cycle when results are taken.
// Synchronous active-high reset empties the queue and returns to header search.
// A stalled result holds at the queue head; input stalls once three wait.
// ---------------------------------------------------------------------------
module rle_image_stream_decoder
   import rlsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // Results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_start_index,
   output logic [15:0] rsp_run_length,
   output logic [7:0]  rsp_color,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_end_of_image,
   // Configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers.
   logic [7:0] tcolor_ff;
   logic       tenable_ff;
   logic       cfg_write;

   // Parser state.
   phase_type  phase_ff,  phase_in;
   logic [3:0] pos_ff,    pos_in;
   logic       wide_ff,   wide_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] seen_ff,  seen_in;
   logic [7:0] held_ff,   held_in;
   logic       hvalid_ff, hvalid_in;
   logic [15:0] acc_ff,   acc_in;
   logic [31:0] pix_ff,   pix_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;

   // Results of the current byte.
   result_type slot0, slot1;
   logic       slot0_v, slot1_v;

   // Result queue.
   result_type                 queue_ff [RESULT_DEPTH];
   logic [RESULT_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [RESULT_CNT_W-1:0]    count_ff;
   logic                       accept, pop;
   logic [RESULT_CNT_W-1:0]    push_n;

   // APB port: always ready, writes on the access phase.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcolor_ff  <= 8'd0;
         tenable_ff <= 1'b0;
      end else if (cfg_write) begin
         if (paddr[2] == REG_TRANSPARENT_COLOR) begin
            tcolor_ff <= pwdata[7:0];
         end else begin
            tenable_ff <= pwdata[0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_TRANSPARENCY_ENABLE) begin
         prdata = {31'd0, tenable_ff};
      end else begin
         prdata = {24'd0, tcolor_ff};
      end
   end

   // Decode one byte: next parser state and up to two results.
   always_comb begin
      logic        bad;
      logic        e1_v, e2_v, e2_req, at_end;
      logic [7:0]  e1_color;
      logic [15:0] e1_len;
      logic [31:0] pix_mid;
      result_type  blank;

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      wide_in   = wide_ff;
      total_in  = total_ff;
      seen_in   = seen_ff;
      held_in   = held_ff;
      hvalid_in = hvalid_ff;
      acc_in    = acc_ff;
      pix_in    = pix_ff;
      width_in  = width_ff;
      height_in = height_ff;

      bad      = 1'b0;
      e1_v     = 1'b0;
      e2_req   = 1'b0;
      e2_v     = 1'b0;
      at_end   = 1'b0;
      e1_color = held_ff;
      e1_len   = 16'd0;
      pix_mid  = pix_ff;

      blank = '0;
      blank.kind         = KIND_RUN;
      blank.image_width  = width_ff;
      blank.image_height = height_ff;
      slot0   = blank;
      slot1   = blank;
      slot0_v = 1'b0;
      slot1_v = 1'b0;

      if (phase_ff == PH_HEADER) begin
         // Header field capture and checks.
         case (pos_ff) inside
            HDR_POS_R:     bad = (req_stream_byte != MAGIC_R);
            HDR_POS_L:     bad = (req_stream_byte != MAGIC_L);
            HDR_POS_E:     bad = (req_stream_byte != MAGIC_E);
            HDR_POS_DEPTH: begin
               bad     = (req_stream_byte != DEPTH_8) && (req_stream_byte != DEPTH_16);
               wide_in = (req_stream_byte == DEPTH_16);
            end
            [HDR_POS_LEN0:HDR_POS_LEN3]: total_in = {total_ff[23:0], req_stream_byte};
            [HDR_POS_WID0:HDR_POS_WID1]: width_in = {width_ff[7:0], req_stream_byte};
            default: height_in = {height_ff[7:0], req_stream_byte};
         endcase

         if (bad) begin
            pos_in  = 4'd0;
            slot0   = '0;
            slot0.kind         = KIND_ERROR;
            slot0.end_of_image = 1'b1;
            slot0_v = 1'b1;
         end else if (pos_ff < HDR_POS_LAST) begin
            pos_in = pos_ff + 4'd1;
         end else begin
            pos_in    = 4'd0;
            seen_in   = 32'd0;
            hvalid_in = 1'b0;
            held_in   = 8'd0;
            acc_in    = 16'd0;
            pix_in    = 32'd0;
            slot0     = '0;
            slot0.kind         = KIND_HEADER;
            slot0.image_width  = width_in;
            slot0.image_height = height_in;
            slot0.end_of_image = (total_in == 32'd0);
            slot0_v   = 1'b1;
            if (total_in != 32'd0) begin
               phase_in = PH_DATA;
            end
         end
      end else begin
         // Payload: literals, run markers and run lengths.
         case (phase_ff)
            PH_DATA: begin
               if (!hvalid_ff) begin
                  held_in   = req_stream_byte;
                  hvalid_in = 1'b1;
                  e2_req    = 1'b1;
               end else if (held_ff != req_stream_byte) begin
                  e1_len  = 16'd1;
                  held_in = req_stream_byte;
                  e2_req  = 1'b1;
               end else begin
                  hvalid_in = 1'b0;
                  acc_in    = 16'd0;
                  phase_in  = wide_ff ? PH_LEN_HI : PH_LEN_LO;
               end
            end
            PH_LEN_HI: begin
               acc_in   = {req_stream_byte, 8'd0};
               phase_in = PH_LEN_LO;
            end
            default: begin
               acc_in   = acc_ff | {8'd0, req_stream_byte};
               phase_in = PH_DATA;
               e1_len   = acc_in;
            end
         endcase

         // First emission, starting at the current pixel index.
         pix_mid = pix_ff + {16'd0, e1_len};
         e1_v    = (e1_len != 16'd0) && !(tenable_ff && (e1_color == tcolor_ff));

         // Payload end: flush a pending byte as a literal.
         seen_in = seen_ff + 32'd1;
         at_end  = (seen_in == total_ff);
         pix_in  = pix_mid;
         if (at_end) begin
            hvalid_in = 1'b0;
            phase_in  = PH_HEADER;
            pos_in    = 4'd0;
            if (e2_req) begin
               pix_in = pix_mid + 32'd1;
               e2_v   = !(tenable_ff && (held_in == tcolor_ff));
            end
         end

         // Order the emissions into the two result slots.
         if (e1_v) begin
            slot0.start_index = pix_ff;
            slot0.run_length  = e1_len;
            slot0.color       = e1_color;
            slot0_v           = 1'b1;
            if (e2_v) begin
               slot1.start_index = pix_mid;
               slot1.run_length  = 16'd1;
               slot1.color       = held_in;
               slot1_v           = 1'b1;
            end
         end else if (e2_v) begin
            slot0.start_index = pix_mid;
            slot0.run_length  = 16'd1;
            slot0.color       = held_in;
            slot0_v           = 1'b1;
         end

         // Mark the last result of the image, or give an empty marker.
         if (at_end) begin
            if (slot1_v) begin
               slot1.end_of_image = 1'b1;
            end else if (slot0_v) begin
               slot0.end_of_image = 1'b1;
            end else begin
               slot0.start_index  = pix_in;
               slot0.end_of_image = 1'b1;
               slot0_v            = 1'b1;
            end
         end
      end
   end

   // Input transfer: room for two results is required.
   assign req_stall = (count_ff > RESULT_CNT_W'(RESULT_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = accept ? (RESULT_CNT_W'(slot0_v) + RESULT_CNT_W'(slot1_v)) : '0;

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= 4'd0;
         wide_ff   <= 1'b0;
         total_ff  <= 32'd0;
         seen_ff   <= 32'd0;
         held_ff   <= 8'd0;
         hvalid_ff <= 1'b0;
         acc_ff    <= 16'd0;
         pix_ff    <= 32'd0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         wide_ff   <= wide_in;
         total_ff  <= total_in;
         seen_ff   <= seen_in;
         held_ff   <= held_in;
         hvalid_ff <= hvalid_in;
         acc_ff    <= acc_in;
         pix_ff    <= pix_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (accept && slot0_v) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (accept && slot1_v) begin
         queue_ff[wr_ptr_ff + RESULT_PTR_W'(1)] <= slot1;
      end
   end

   // Result queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n[RESULT_PTR_W-1:0];
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RESULT_PTR_W'(1);
         end
         count_ff <= count_ff + push_n - RESULT_CNT_W'(pop);
      end
   end

   // Queue head drives the result ports.
   assign rsp_kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_start_index  = queue_ff[rd_ptr_ff].start_index;
   assign rsp_run_length   = queue_ff[rd_ptr_ff].run_length;
   assign rsp_color        = queue_ff[rd_ptr_ff].color;
   assign rsp_image_width  = queue_ff[rd_ptr_ff].image_width;
   assign rsp_image_height = queue_ff[rd_ptr_ff].image_height;
   assign rsp_end_of_image = queue_ff[rd_ptr_ff].end_of_image;

endmodule

// ===== rtl/core/rlsd_checker.sv =====
// ---------------------------------------------------------------------------
// RLE image stream decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "rle_image_stream_decoder_defines.svh"

module rlsd_checker
   import rlsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_start_index,
   input logic [15:0] rsp_run_length,
   input logic        rsp_end_of_image
);

   // A stalled result stays offered and unchanged.
   `RLSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_start_index) && $stable(rsp_run_length))

   // Every format error closes the image and carries no run.
   `RLSD_ASSERT_IMPLY(a_error_closes, clock, reset, rsp_valid && (rsp_kind == KIND_ERROR), rsp_end_of_image && (rsp_run_length == 16'd0) && (rsp_start_index == 32'd0))

   // A header result carries no run.
   `RLSD_ASSERT_IMPLY(a_header_empty, clock, reset, rsp_valid && (rsp_kind == KIND_HEADER), (rsp_run_length == 16'd0) && (rsp_start_index == 32'd0))

   // An empty run appears only as the end-of-image marker.
   `RLSD_ASSERT_IMPLY(a_run_nonzero, clock, reset, rsp_valid && (rsp_kind == KIND_RUN) && !rsp_end_of_image, rsp_run_length != 16'd0)

endmodule

bind rle_image_stream_decoder rlsd_checker u_rlsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_start_index  (rsp_start_index),
   .rsp_run_length   (rsp_run_length),
   .rsp_end_of_image (rsp_end_of_image)
);
